// ===== rtl/cgsf_pkg.sv =====
// Package for the character grid shape fill unit.
// Holds grid sizes, command codes, register indexes and request/response types.
// No dependencies.
package cgsf_pkg;

   localparam int MAX_COLS   = 128;
   localparam int MAX_ROWS   = 64;
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int ADDR_W     = COL_W + ROW_W;
   localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
   localparam int CNT_W      = 14;

   localparam logic [2:0] MODE_BOX_OUTLINE = 3'd0;
   localparam logic [2:0] MODE_BOX_FILL    = 3'd1;
   localparam logic [2:0] MODE_DISK_FILL   = 3'd2;
   localparam logic [2:0] MODE_READ_CELL   = 3'd3;
   localparam logic [2:0] MODE_WRITE_CELL  = 3'd4;

   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   typedef struct packed {
      logic [2:0] mode;
      logic [6:0] corner_col;
      logic [5:0] corner_row;
      logic [6:0] start_col;
      logic [5:0] start_row;
      logic [6:0] radius;
      logic [7:0] fill_char;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_char;
      logic [13:0] cells_written;
   } rsp_type;

endpackage

// ===== rtl/char_grid_shape_fill_unit.sv =====
// Character grid shape fill unit: box outline/fill, disk fill, cell read/write.
// Box and disk shapes scan every cell of the grid region in use; cell read and write act on one cell.
// The unit takes one request at a time: start is taken only while busy is low.
// Reset: synchronous; a clearing pass writes zero to every cell of the grid memory, with busy high.
// The receiver cannot stall: each response is a one-cycle strobe on rsp_valid.
// Depends on cgsf_pkg.
module char_grid_shape_fill_unit
   import cgsf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_type       req_data,
   output logic          rsp_valid,
   output rsp_type       rsp_data,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [7:0]    csr_wdata
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_READ  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [7:0]          grid_width_ff;
   logic [6:0]          grid_height_ff;
   req_type             cmd_ff, cmd_in;
   logic [13:0]         r_sq_ff, r_sq_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic [7:0]          map_mem [CELL_COUNT];
   logic [7:0]          rd_data_ff;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_addr;
   logic [7:0]          mem_wdata;
   logic [ADDR_W-1:0]   rd_addr;

   logic [7:0]          used_cols;
   logic [6:0]          used_rows;
   logic [COL_W-1:0]    last_col;
   logic [ROW_W-1:0]    last_row;
   logic                region_empty;
   logic                cell_in_region;
   logic [6:0]          dx_abs;
   logic [5:0]          dy_abs;
   logic [14:0]         dist_sq;
   logic                box_hit;
   logic                edge_hit;
   logic                hit;

   assign used_cols    = (grid_width_ff > 8'(MAX_COLS)) ? 8'(MAX_COLS) : grid_width_ff;
   assign used_rows    = (grid_height_ff > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : grid_height_ff;
   assign last_col     = COL_W'(used_cols - 8'd1);
   assign last_row     = ROW_W'(used_rows - 7'd1);
   assign region_empty = (used_cols == 8'd0) || (used_rows == 7'd0);
   assign cell_in_region = ({1'b0, req_data.corner_col} < used_cols) &&
                           ({1'b0, req_data.corner_row} < used_rows);

   assign dx_abs  = (col_ff >= cmd_ff.corner_col) ? 7'(col_ff - cmd_ff.corner_col)
                                                  : 7'(cmd_ff.corner_col - col_ff);
   assign dy_abs  = (row_ff >= cmd_ff.corner_row) ? 6'(row_ff - cmd_ff.corner_row)
                                                  : 6'(cmd_ff.corner_row - row_ff);
   assign dist_sq = (15'(dx_abs) * 15'(dx_abs)) + (15'(dy_abs) * 15'(dy_abs));

   assign box_hit  = (cmd_ff.start_col <= col_ff) && (col_ff <= cmd_ff.corner_col) &&
                     (cmd_ff.start_row <= row_ff) && (row_ff <= cmd_ff.corner_row);
   assign edge_hit = (row_ff == cmd_ff.start_row) || (row_ff == cmd_ff.corner_row) ||
                     (col_ff == cmd_ff.start_col) || (col_ff == cmd_ff.corner_col);

   always_comb begin
      case (cmd_ff.mode)
         MODE_BOX_OUTLINE: hit = box_hit && edge_hit;
         MODE_BOX_FILL:    hit = box_hit;
         MODE_DISK_FILL:   hit = dist_sq <= {1'b0, r_sq_ff};
         default:          hit = 1'b0;
      endcase
   end

   assign rd_addr = {req_data.corner_row, req_data.corner_col};

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      r_sq_in      = r_sq_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      clr_addr_in  = clr_addr_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_addr     = {row_ff, col_ff};
      mem_wdata    = cmd_ff.fill_char;

      case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_addr    = clr_addr_ff;
            mem_wdata   = 8'd0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd_in   = req_data;
               r_sq_in  = 14'(req_data.radius) * 14'(req_data.radius);
               col_in   = '0;
               row_in   = '0;
               count_in = '0;
               rsp_data_in = '0;
               case (req_data.mode) inside
                  MODE_BOX_OUTLINE, MODE_BOX_FILL, MODE_DISK_FILL: begin
                     if (region_empty) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  MODE_READ_CELL: begin
                     if (cell_in_region) begin
                        state_in = ST_READ;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  MODE_WRITE_CELL: begin
                     rsp_valid_in = 1'b1;
                     if (cell_in_region) begin
                        mem_we    = 1'b1;
                        mem_addr  = rd_addr;
                        mem_wdata = req_data.fill_char;
                        rsp_data_in.cells_written = CNT_W'(1);
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            mem_we   = hit;
            count_in = count_ff + CNT_W'(hit);
            if (col_ff == last_col) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
               if (row_ff == last_row) begin
                  state_in                  = ST_IDLE;
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.read_char     = 8'd0;
                  rsp_data_in.cells_written = count_ff + CNT_W'(hit);
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_READ: begin
            state_in                  = ST_IDLE;
            rsp_valid_in              = 1'b1;
            rsp_data_in.read_char     = rd_data_ff;
            rsp_data_in.cells_written = '0;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         grid_width_ff  <= 8'(MAX_COLS);
         grid_height_ff <= 7'(MAX_ROWS);
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && (csr_index == CSR_GRID_WIDTH)) begin
            grid_width_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == CSR_GRID_HEIGHT)) begin
            grid_height_ff <= csr_wdata[6:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      r_sq_ff     <= r_sq_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
